// ----- rtl/tfd_pkg.sv -----
// ----------------------------------------------------------------------------
// tfd_pkg
// Types and constants shared by the tunnel frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tfd_pkg;

  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned HDR_POS_W    = $clog2(HEADER_BYTES);

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 20;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 1'b1;

  localparam logic [19:0] TIMEOUT_RESET     = 20'd20000;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hFFFF;
  localparam logic [19:0] ELAPSED_MAX       = 20'hFFFFF;

  localparam logic [7:0] MAGIC [4] = '{8'h48, 8'h4E, 8'h42, 8'h31};
  localparam logic [7:0] FRAME_VERSION = 8'h01;
  localparam logic [7:0] KIND_IP       = 8'h20;
  localparam logic [7:0] KIND_PING     = 8'h30;
  localparam logic [31:0] IP_MIN_LEN   = 32'd20;
  localparam logic [31:0] PING_LEN     = 32'd8;
  localparam logic [3:0] IPV4_VERSION  = 4'd4;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MALFORMED = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT   = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_FAILED  = 3'b100
  } phase_t;

  typedef enum logic {
    ITEM_BYTE = 1'b0,
    ITEM_TICK = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        to_echo;
    logic        last_byte;
    logic        packet_ok;
    logic        failed;
    logic [1:0]  error_code;
    logic [31:0] packets_delivered;
    logic [31:0] bytes_delivered;
  } out_item_t;

  // classified item as held in the queue
  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data;
  } q_entry_t;

  typedef struct packed {
    logic [19:0] timeout_ticks;
    logic [15:0] max_payload;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/tfd_in_if.sv -----
// ----------------------------------------------------------------------------
// tfd_in_if
// Input stream: valid/ready handshake carrying link bytes and ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfd_in_if;
  logic             valid;
  logic             ready;
  tfd_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/tfd_out_if.sv -----
// ----------------------------------------------------------------------------
// tfd_out_if
// Output stream: valid/ready handshake carrying one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfd_out_if;
  logic              valid;
  logic              ready;
  tfd_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/tfd_front.sv -----
// ----------------------------------------------------------------------------
// tfd_front
// Accepts input items, classifies them as byte or tick, and pushes them
// into the queue from a registered stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_front (
  input  wire logic        clk,
  input  wire logic        rst,
  tfd_in_if.sink           in_ch,
  input  wire logic        q_full,
  output logic             q_push,
  output tfd_pkg::q_entry_t q_wdata
);
  import tfd_pkg::*;

  logic     stage_valid;
  q_entry_t stage;

  assign q_push      = stage_valid && !q_full;
  assign q_wdata     = stage;
  assign in_ch.ready = !stage_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage.kind <= in_ch.payload.operation ? ITEM_TICK : ITEM_BYTE;
      stage.data <= in_ch.payload.in_byte;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tfd_queue.sv -----
// ----------------------------------------------------------------------------
// tfd_queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tfd_pkg::q_entry_t wdata,
  input  wire logic              pop,
  output logic                   full,
  output logic                   empty,
  output tfd_pkg::q_entry_t      rdata
);
  import tfd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  q_entry_t      slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tfd_back.sv -----
// ----------------------------------------------------------------------------
// tfd_back
// Frame state machine: header check, payload pass-through, timeout,
// counters, and the output register toward the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tfd_pkg::cfg_t     cfg,
  input  wire logic              q_empty,
  input  wire tfd_pkg::q_entry_t q_rdata,
  output logic                   q_pop,
  tfd_out_if.source              out_ch
);
  import tfd_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic        header_bad, header_bad_next;
  logic [7:0]  frame_kind, frame_kind_next;
  logic [31:0] frame_length, frame_length_next;
  logic [31:0] frame_sequence, frame_sequence_next;
  logic [31:0] expected_sequence, expected_sequence_next;
  logic [15:0] ip_total_length, ip_total_length_next;
  logic        ip_bad, ip_bad_next;
  logic [19:0] elapsed_ticks, elapsed_ticks_next;
  logic [1:0]  sticky_error, sticky_error_next;
  logic [31:0] packet_count, packet_count_next;
  logic [31:0] byte_count, byte_count_next;

  logic        out_valid;
  out_item_t   out_data, result;

  assign q_pop          = !q_empty && (!out_valid || out_ch.ready);
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_data;

  always_comb begin
    logic [HDR_POS_W-1:0] hdr_pos;
    logic [19:0]          ticks;
    logic                 bad;
    logic                 is_ping;
    logic [16:0]          pos_plus1;
    logic [7:0]           b;

    phase_next             = phase;
    byte_position_next     = byte_position;
    header_bad_next        = header_bad;
    frame_kind_next        = frame_kind;
    frame_length_next      = frame_length;
    frame_sequence_next    = frame_sequence;
    expected_sequence_next = expected_sequence;
    ip_total_length_next   = ip_total_length;
    ip_bad_next            = ip_bad;
    elapsed_ticks_next     = elapsed_ticks;
    sticky_error_next      = sticky_error;
    packet_count_next      = packet_count;
    byte_count_next        = byte_count;

    result    = '0;
    b         = q_rdata.data;
    hdr_pos   = byte_position[HDR_POS_W-1:0];
    ticks     = (elapsed_ticks < ELAPSED_MAX) ? elapsed_ticks + 1'b1 : elapsed_ticks;
    is_ping   = (frame_kind == KIND_PING);
    pos_plus1 = {1'b0, byte_position} + 17'd1;
    bad       = 1'b0;

    if (q_pop && phase != PH_FAILED) begin
      if (q_rdata.kind == ITEM_TICK) begin
        elapsed_ticks_next = ticks;
        if (ticks >= cfg.timeout_ticks) begin
          phase_next = PH_FAILED;
          if (sticky_error == ERR_NONE) sticky_error_next = ERR_TIMEOUT;
        end
      end else if (phase == PH_HEADER) begin
        unique case (hdr_pos) inside
          [4'd0:4'd3]: begin
            if (b != MAGIC[hdr_pos[1:0]]) header_bad_next = 1'b1;
          end
          4'd4: begin
            if (b != FRAME_VERSION) header_bad_next = 1'b1;
          end
          4'd5: begin
            frame_kind_next = b;
          end
          [4'd6:4'd7]: begin
            if (b != 8'd0) header_bad_next = 1'b1;
          end
          [4'd8:4'd11]: begin
            frame_length_next = {frame_length[23:0], b};
          end
          default: begin
            frame_sequence_next = {frame_sequence[23:0], b};
          end
        endcase
        byte_position_next = pos_plus1[15:0];

        if (hdr_pos == HDR_POS_W'(HEADER_BYTES - 1)) begin
          // full header in: frame_length is already complete at this point
          bad = header_bad_next;
          if (frame_length > {16'd0, cfg.max_payload}) bad = 1'b1;
          if (frame_sequence_next != expected_sequence) bad = 1'b1;
          if (frame_kind == KIND_IP) begin
            if (frame_length < IP_MIN_LEN) bad = 1'b1;
          end else if (frame_kind == KIND_PING) begin
            if (frame_length != PING_LEN) bad = 1'b1;
          end else begin
            bad = 1'b1;
          end
          if (bad) begin
            phase_next = PH_FAILED;
            if (sticky_error == ERR_NONE) sticky_error_next = ERR_MALFORMED;
          end else begin
            phase_next           = PH_PAYLOAD;
            byte_position_next   = '0;
            ip_total_length_next = '0;
            ip_bad_next          = 1'b0;
            elapsed_ticks_next   = '0;
          end
        end
      end else begin
        result.out_byte   = b;
        result.byte_valid = 1'b1;
        result.to_echo    = is_ping;
        if (!is_ping) begin
          if (byte_position == 16'd0 && b[7:4] != IPV4_VERSION) begin
            ip_bad_next = 1'b1;
          end else if (byte_position == 16'd2 || byte_position == 16'd3) begin
            ip_total_length_next = {ip_total_length[7:0], b};
          end
        end
        byte_position_next = pos_plus1[15:0];

        if ({15'd0, pos_plus1} >= frame_length) begin
          result.last_byte = 1'b1;
          expected_sequence_next = (expected_sequence == '1) ? 32'd1
                                                              : expected_sequence + 32'd1;
          if (!is_ping && (ip_bad_next || {16'd0, ip_total_length_next} != frame_length))
          begin
            phase_next = PH_FAILED;
            if (sticky_error == ERR_NONE) sticky_error_next = ERR_MALFORMED;
          end else begin
            result.packet_ok = 1'b1;
            if (!is_ping) begin
              packet_count_next = packet_count + 32'd1;
              byte_count_next   = byte_count + frame_length;
            end
            // back to header collection
            phase_next          = PH_HEADER;
            byte_position_next  = '0;
            header_bad_next     = 1'b0;
            frame_kind_next     = '0;
            frame_length_next   = '0;
            frame_sequence_next = '0;
            elapsed_ticks_next  = '0;
          end
        end
      end
    end

    result.failed            = (phase_next == PH_FAILED);
    result.error_code        = sticky_error_next;
    result.packets_delivered = packet_count_next;
    result.bytes_delivered   = byte_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      byte_position     <= '0;
      header_bad        <= 1'b0;
      frame_kind        <= '0;
      frame_length      <= '0;
      frame_sequence    <= '0;
      expected_sequence <= 32'd2;
      ip_total_length   <= '0;
      ip_bad            <= 1'b0;
      elapsed_ticks     <= '0;
      sticky_error      <= ERR_NONE;
      packet_count      <= '0;
      byte_count        <= '0;
      out_valid         <= 1'b0;
    end else begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      header_bad        <= header_bad_next;
      frame_kind        <= frame_kind_next;
      frame_length      <= frame_length_next;
      frame_sequence    <= frame_sequence_next;
      expected_sequence <= expected_sequence_next;
      ip_total_length   <= ip_total_length_next;
      ip_bad            <= ip_bad_next;
      elapsed_ticks     <= elapsed_ticks_next;
      sticky_error      <= sticky_error_next;
      packet_count      <= packet_count_next;
      byte_count        <= byte_count_next;
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tunnel_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// tunnel_frame_deframer
// Tunnel link receiver: header check, payload pass-through and counters.
// ----------------------------------------------------------------------------
// in_ch carries one item per handshake: a link byte or a 1 ms tick.
// out_ch returns exactly one result per item, in order: the payload byte
// (with tunnel/echo marking and last-byte verdict), the sticky error and the
// delivered-packet and delivered-byte counters.
// wr_en/wr_index/wr_data write timeout_ticks (index 0) and max_payload
// (index 1); write only while no items are in flight.
// Throughput: one item per cycle sustained while out_ch does not stall. The
// frame state update in the back part is registered once per item and sets that rate.
// Path: an accepted item passes the input stage, the queue and the output
// register in that order before its result is valid on out_ch.
// Reset clears the frame state, counters and error, sets the expected
// sequence to 2 and loads the register defaults; no clearing pass follows.
// When out_ch stalls, the output register holds its result, the queue fills
// and in_ch.ready drops only once the queue and the input stage are full.
// ----------------------------------------------------------------------------
`default_nettype none

module tunnel_frame_deframer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  tfd_in_if.sink                                in_ch,
  tfd_out_if.source                             out_ch,
  input  wire logic                             wr_en,
  input  wire logic [tfd_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [tfd_pkg::CFG_DATA_W-1:0]  wr_data
);
  import tfd_pkg::*;

  cfg_t     cfg;
  logic     q_push, q_pop, q_full, q_empty;
  q_entry_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TIMEOUT_RESET;
      cfg.max_payload   <= MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TIMEOUT:     cfg.timeout_ticks <= wr_data[19:0];
        CFG_MAX_PAYLOAD: cfg.max_payload   <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  tfd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  tfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  tfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_fail_has_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.payload.failed |-> out_ch.payload.error_code != ERR_NONE)
    else $error("failed result without an error code");

  a_ok_on_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.payload.packet_ok |->
      out_ch.payload.last_byte && out_ch.payload.byte_valid && !out_ch.payload.failed)
    else $error("packet_ok outside a clean last byte");

  a_echo_marks_byte: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.payload.to_echo |-> out_ch.payload.byte_valid)
    else $error("echo marking on a result without a byte");

  a_pop_loads_output: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> out_ch.valid)
    else $error("queue pop did not produce a result");

endmodule

`default_nettype wire

// ----- tb/sv/tfd_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tfd_checker
// Watches the link and result channels of the deframer and the register port,
// predicts one result per accepted item and compares results field by field.
// ----------------------------------------------------------------------------
module tfd_checker (
  input  logic                            clk,
  input  logic                            rst,
  tfd_in_if                               link_if,
  tfd_out_if                              result_if,
  input  logic                            wr_en,
  input  logic [tfd_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [tfd_pkg::CFG_DATA_W-1:0]  wr_data,
  output int                              fail_count,
  output int                              pending
);
  import tfd_pkg::*;

  // register copies
  logic [19:0] tmo;
  logic [15:0] maxp;

  // frame state
  phase_t      ph;
  logic [15:0] pos;
  logic        hdr_bad;
  logic [7:0]  kind;
  logic [31:0] flen;
  logic [31:0] fseq;
  logic [31:0] want_seq;
  logic [15:0] ip_len;
  logic        ip_bad;
  logic [19:0] ticks;
  logic [1:0]  err;
  logic [31:0] pkts;
  logic [31:0] byte_total;

  out_item_t   frame_results_q[$];
  out_item_t   want;

  function automatic void restart_header();
    ph      = PH_HEADER;
    pos     = '0;
    hdr_bad = 1'b0;
    kind    = '0;
    flen    = '0;
    fseq    = '0;
    ticks   = '0;
  endfunction

  function automatic void enter_fail(logic [1:0] code);
    if (err == ERR_NONE) begin
      err = code;
    end
    ph = PH_FAILED;
  endfunction

  function automatic void take_header_byte(logic [7:0] b);
    logic [15:0] at;
    logic        bad;
    at = pos;
    if (at < 4) begin
      if (b != MAGIC[at[1:0]]) hdr_bad = 1'b1;
    end else if (at == 4) begin
      if (b != FRAME_VERSION) hdr_bad = 1'b1;
    end else if (at == 5) begin
      kind = b;
    end else if (at < 8) begin
      if (b != 8'h00) hdr_bad = 1'b1;
    end else if (at < 12) begin
      flen = {flen[23:0], b};
    end else begin
      fseq = {fseq[23:0], b};
    end
    pos = at + 16'd1;
    // whole header in: run every header check at once
    if ({16'd0, at} + 32'd1 >= HEADER_BYTES) begin
      bad = hdr_bad;
      if (flen > {16'd0, maxp}) bad = 1'b1;
      if (fseq != want_seq) bad = 1'b1;
      if (kind == KIND_IP) begin
        if (flen < IP_MIN_LEN) bad = 1'b1;
      end else if (kind == KIND_PING) begin
        if (flen != PING_LEN) bad = 1'b1;
      end else begin
        bad = 1'b1;
      end
      if (bad) begin
        enter_fail(ERR_MALFORMED);
      end else begin
        ph     = PH_PAYLOAD;
        pos    = '0;
        ip_len = '0;
        ip_bad = 1'b0;
        ticks  = '0;
      end
    end
  endfunction

  function automatic out_item_t deframe_predict(in_item_t it);
    out_item_t   r;
    logic [15:0] at;
    logic        is_ping;
    r = '0;
    if (ph != PH_FAILED) begin
      if (it.operation == ITEM_TICK) begin
        if (ticks < ELAPSED_MAX) ticks = ticks + 20'd1;
        if (ticks >= tmo) enter_fail(ERR_TIMEOUT);
      end else if (ph == PH_HEADER) begin
        take_header_byte(it.in_byte);
      end else begin
        at           = pos;
        is_ping      = (kind == KIND_PING);
        r.out_byte   = it.in_byte;
        r.byte_valid = 1'b1;
        r.to_echo    = is_ping;
        if (!is_ping) begin
          if (at == 0 && it.in_byte[7:4] != IPV4_VERSION) begin
            ip_bad = 1'b1;
          end else if (at == 2 || at == 3) begin
            ip_len = {ip_len[7:0], it.in_byte};
          end
        end
        pos = at + 16'd1;
        if ({16'd0, at} + 32'd1 >= flen) begin
          r.last_byte = 1'b1;
          want_seq = (want_seq == '1) ? 32'd1 : want_seq + 32'd1;
          if (is_ping) begin
            r.packet_ok = 1'b1;
            restart_header();
          end else if (ip_bad || {16'd0, ip_len} != flen) begin
            enter_fail(ERR_MALFORMED);
          end else begin
            r.packet_ok = 1'b1;
            pkts        = pkts + 32'd1;
            byte_total  = byte_total + flen;
            restart_header();
          end
        end
      end
    end
    r.failed            = (ph == PH_FAILED);
    r.error_code        = err;
    r.packets_delivered = pkts;
    r.bytes_delivered   = byte_total;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tmo  = TIMEOUT_RESET;
      maxp = MAX_PAYLOAD_RESET;
      restart_header();
      want_seq   = 32'd2;
      ip_len     = '0;
      ip_bad     = 1'b0;
      err        = ERR_NONE;
      pkts       = '0;
      byte_total = '0;
      frame_results_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          CFG_TIMEOUT:     tmo  = wr_data[19:0];
          CFG_MAX_PAYLOAD: maxp = wr_data[15:0];
        endcase
      end
      if (result_if.valid && result_if.ready) begin
        if (frame_results_q.size() == 0) begin
          $error("result item arrived with nothing outstanding");
          fail_count++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("out_byte", 32'(want.out_byte), 32'(result_if.payload.out_byte));
          check_field("byte_valid", 32'(want.byte_valid),
                      32'(result_if.payload.byte_valid));
          check_field("to_echo", 32'(want.to_echo), 32'(result_if.payload.to_echo));
          check_field("last_byte", 32'(want.last_byte), 32'(result_if.payload.last_byte));
          check_field("packet_ok", 32'(want.packet_ok), 32'(result_if.payload.packet_ok));
          check_field("failed", 32'(want.failed), 32'(result_if.payload.failed));
          check_field("error_code", 32'(want.error_code),
                      32'(result_if.payload.error_code));
          check_field("packets_delivered", want.packets_delivered,
                      result_if.payload.packets_delivered);
          check_field("bytes_delivered", want.bytes_delivered,
                      result_if.payload.bytes_delivered);
        end
      end
      if (link_if.valid && link_if.ready) begin
        frame_results_q.push_back(deframe_predict(link_if.payload));
      end
    end
    pending = frame_results_q.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the tunnel frame deframer: well-formed IP and ping frames with
// ticks mixed in, under several register settings and idle patterns, ending
// with one randomly chosen malformed frame or timeout.
// ----------------------------------------------------------------------------
module testbench;
  import tfd_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 400;
  localparam int TICK_PCT     = 12;

  // the error state is sticky and reset is applied once, so a run ends on one fault
  typedef enum int {
    FAULT_NONE,
    FAULT_MAGIC,
    FAULT_VERSION,
    FAULT_RESERVED,
    FAULT_KIND,
    FAULT_SEQUENCE,
    FAULT_TOO_LONG,
    FAULT_IP_SHORT,
    FAULT_PING_LENGTH,
    FAULT_IP_VERSION,
    FAULT_IP_LENGTH,
    FAULT_TIMEOUT
  } fault_t;

  logic                   clk;
  logic                   rst;
  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;
  int                     fail_count;
  int                     pending;

  tfd_in_if  link_if();
  tfd_out_if result_if();

  tunnel_frame_deframer uut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (link_if),
    .out_ch   (result_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  tfd_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .link_if    (link_if),
    .result_if  (result_if),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  int          sender_idle_pct;
  int          receiver_idle_pct;
  bit          long_hold_req;
  bit          hold_started;
  int          hold_left;
  int          cycles;
  logic [19:0] cur_tmo;
  int          cur_maxp;
  logic [31:0] next_seq;
  int          phase_ticks;
  int          items_sent;
  int          ip_frames;
  int          ping_frames;
  int          ticks_sent;
  fault_t      fault;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side: random back-pressure plus one long hold on request
  initial begin
    result_if.ready = 1'b0;
    hold_left = 0;
    hold_started = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_started) begin
        hold_left = LONG_HOLD;
        hold_started = 1'b1;
      end
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else begin
        result_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // called at a rising edge; returns at the edge where the item was taken
  task automatic push_item(input logic op, input logic [7:0] b);
    in_item_t item;
    item.operation = op;
    item.in_byte = b;
    while ($urandom_range(99) < sender_idle_pct) begin
      link_if.valid <= 1'b0;
      @(posedge clk);
    end
    link_if.valid <= 1'b1;
    link_if.payload <= item;
    @(negedge clk);
    while (!link_if.ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // ticks stay below the timeout of the current header or payload phase
  task automatic push_link_byte(input logic [7:0] b);
    while (phase_ticks + 1 < cur_tmo && $urandom_range(99) < TICK_PCT) begin
      push_item(ITEM_TICK, 8'($urandom));
      phase_ticks++;
      ticks_sent++;
    end
    push_item(ITEM_BYTE, b);
  endtask

  task automatic send_frame(input logic [7:0] frame_kind, input logic [31:0] len,
                            input fault_t flt, input bit extremes);
    logic [7:0]  hdr [16];
    logic [31:0] seq_field;
    logic [15:0] ip_len_field;
    logic [7:0]  b;
    int          i;
    seq_field = (flt == FAULT_SEQUENCE) ? next_seq ^ (32'd1 << $urandom_range(31))
                                        : next_seq;
    for (i = 0; i < 4; i++) begin
      hdr[i]      = MAGIC[i];
      hdr[8 + i]  = len[31 - 8 * i -: 8];
      hdr[12 + i] = seq_field[31 - 8 * i -: 8];
    end
    hdr[4] = FRAME_VERSION;
    hdr[5] = frame_kind;
    hdr[6] = 8'h00;
    hdr[7] = 8'h00;
    case (flt)
      FAULT_MAGIC:    hdr[$urandom_range(3)] ^= 8'd1 << $urandom_range(7);
      FAULT_VERSION:  hdr[4] ^= 8'd1 << $urandom_range(7);
      FAULT_RESERVED: hdr[6 + $urandom_range(1)] = 8'($urandom_range(1, 255));
      FAULT_KIND: begin
        do hdr[5] = 8'($urandom); while (hdr[5] == KIND_IP || hdr[5] == KIND_PING);
      end
      default: ;
    endcase
    for (i = 0; i < 16; i++) push_link_byte(hdr[i]);
    phase_ticks = 0;
    if (flt == FAULT_NONE || flt == FAULT_IP_VERSION || flt == FAULT_IP_LENGTH) begin
      ip_len_field = len[15:0];
      if (flt == FAULT_IP_LENGTH) ip_len_field ^= 16'd1 << $urandom_range(15);
      for (i = 0; i < len; i++) begin
        b = extremes ? ((i % 2 == 0) ? 8'h00 : 8'hFF) : 8'($urandom);
        if (frame_kind == KIND_IP) begin
          if (i == 0) begin
            b[7:4] = (flt == FAULT_IP_VERSION) ? IPV4_VERSION ^ (4'd1 << $urandom_range(3))
                                               : IPV4_VERSION;
          end else if (i == 2) begin
            b = ip_len_field[15:8];
          end else if (i == 3) begin
            b = ip_len_field[7:0];
          end
        end
        push_link_byte(b);
      end
      phase_ticks = 0;
      next_seq = (next_seq == '1) ? 32'd1 : next_seq + 32'd1;
      if (frame_kind == KIND_IP) ip_frames++;
      else ping_frames++;
    end
  endtask

  function automatic int pick_ip_len();
    int cap;
    int short_cap;
    int r;
    cap = (cur_maxp < 600) ? cur_maxp : 600;
    short_cap = (cap < 64) ? cap : 64;
    r = $urandom_range(99);
    if (r < 8) return cap;
    if (r < 20) return $urandom_range(20, cap);
    return $urandom_range(20, short_cap);
  endfunction

  task automatic run_frames(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(99) < 25) send_frame(KIND_PING, PING_LEN, FAULT_NONE, 1'b0);
      else send_frame(KIND_IP, pick_ip_len(), FAULT_NONE, 1'b0);
    end
  endtask

  // registers change only with nothing in flight
  task automatic wait_drained();
    link_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [19:0] tmo, input logic [15:0] maxp);
    logic [3:0] junk;
    junk = 4'($urandom);
    wr_en    <= 1'b1;
    wr_index <= CFG_TIMEOUT;
    wr_data  <= tmo;
    @(posedge clk);
    wr_index <= CFG_MAX_PAYLOAD;
    wr_data  <= {junk, maxp};  // upper bits must be dropped
    @(posedge clk);
    wr_en    <= 1'b0;
    cur_tmo  = tmo;
    cur_maxp = maxp;
  endtask

  // hold: the receiver stalls for a long stretch while this phase sends
  task automatic run_phase(input logic [19:0] tmo, input logic [15:0] maxp,
                           input int send_idle, input int recv_idle, input int target,
                           input bit hold);
    wait_drained();
    write_regs(tmo, maxp);
    sender_idle_pct   = send_idle;
    receiver_idle_pct = recv_idle;
    if (hold) long_hold_req = 1'b1;
    run_frames(target);
  endtask

  task automatic run_fault();
    logic [19:0] tmo;
    logic [31:0] len;
    fault = fault_t'($urandom_range(FAULT_MAGIC, FAULT_TIMEOUT));
    tmo = (fault == FAULT_TIMEOUT && $urandom_range(1)) ? 20'd0 : 20'($urandom_range(2, 9));
    wait_drained();
    write_regs(tmo, 16'($urandom_range(20, 100)));
    run_frames(60);
    case (fault)
      FAULT_TOO_LONG: begin
        len = $urandom_range(1) ? 32'(cur_maxp + 1 + $urandom_range(50))
                                : 32'hFFFF_FFFF - $urandom_range(3);
        send_frame(KIND_IP, len, fault, 1'b0);
      end
      FAULT_IP_SHORT: send_frame(KIND_IP, $urandom_range(19), fault, 1'b0);
      FAULT_PING_LENGTH: begin
        len = $urandom_range(30);
        if (len >= PING_LEN) len++;
        send_frame(KIND_PING, len, fault, 1'b0);
      end
      FAULT_TIMEOUT: begin
        // header timer runs before any header byte; a zero timeout trips on one tick
        do begin
          push_item(ITEM_TICK, 8'($urandom));
          phase_ticks++;
          ticks_sent++;
        end while (phase_ticks < cur_tmo);
      end
      FAULT_IP_VERSION, FAULT_IP_LENGTH: send_frame(KIND_IP, pick_ip_len(), fault, 1'b0);
      default: begin
        if ($urandom_range(1)) send_frame(KIND_IP, pick_ip_len(), fault, 1'b0);
        else send_frame(KIND_PING, PING_LEN, fault, 1'b0);
      end
    endcase
    // everything after the fault is ignored by the block
    repeat (20) push_item(1'($urandom_range(1)), 8'($urandom));
  endtask

  initial begin
    rst               = 1'b1;
    wr_en             = 1'b0;
    wr_index          = '0;
    wr_data           = '0;
    link_if.valid     = 1'b0;
    link_if.payload   = '0;
    long_hold_req     = 1'b0;
    sender_idle_pct   = 16;
    receiver_idle_pct = 63;
    cur_tmo           = TIMEOUT_RESET;
    cur_maxp          = MAX_PAYLOAD_RESET;
    next_seq          = 32'd2;
    phase_ticks       = 0;
    items_sent        = 0;
    ip_frames         = 0;
    ping_frames       = 0;
    ticks_sent        = 0;
    fault             = FAULT_NONE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: ticks before the first header byte, then a ping of 00/FF bytes
    push_item(ITEM_TICK, 8'h00);
    push_item(ITEM_TICK, 8'hFF);
    phase_ticks = 2;
    ticks_sent += 2;
    send_frame(KIND_PING, PING_LEN, FAULT_NONE, 1'b1);

    run_phase(20'hFFFFF, 16'hFFFF, 16, 63, 500, 1'b0);
    run_phase(20'd1, 16'd20, 63, 16, 400, 1'b0);
    run_phase(20'd4, 16'd300, 0, 0, 500, 1'b1);
    run_fault();

    wait_drained();
    $display("Sent %0d items: %0d IP frames, %0d ping frames, %0d ticks", items_sent,
             ip_frames, ping_frames, ticks_sent);
    $display("Five register settings covered; run closed with a %s case", fault.name());
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
